### rtl/move_speed_ramp_and_arrival_defines.svh
// Assertion helpers for the RTL; they expect clk and rst_n in scope.
`ifndef MOVE_SPEED_RAMP_AND_ARRIVAL_DEFINES_SVH
`define MOVE_SPEED_RAMP_AND_ARRIVAL_DEFINES_SVH

// Same-cycle implication.
`define MSRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msra assertion failed");

// Next-cycle implication.
`define MSRA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msra assertion failed");

`endif

### rtl/msra_pkg.sv
package msra_pkg;

    localparam int X_W    = 24;             // ramp position / accel distance
    localparam int SPAN_W = 16;             // command span, also quotient width
    localparam int ACC_W  = X_W + SPAN_W;   // product width
    localparam int CNT_W  = $clog2(SPAN_W);

    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_TRANS = 2'd1,
        ACT_ROT   = 2'd2
    } act_t;

    localparam logic [1:0] KIND_TRANS = 2'd0;
    localparam logic [1:0] KIND_ROT   = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // boost register bits
    localparam int BOOST_DIST_BIT   = 0;
    localparam int BOOST_ORIENT_BIT = 1;
    localparam logic [1:0] BOOST_NONE    = 2'b00;
    localparam logic [1:0] BOOST_DIST2   = 2'b01;
    localparam logic [1:0] BOOST_ORIENT2 = 2'b10;

    localparam logic [1:0] BOOST_X1 = 2'd1;
    localparam logic [1:0] BOOST_X2 = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ACCEL_DIST  = 3'd0;
    localparam logic [2:0] REG_FULL_CMD    = 3'd1;
    localparam logic [2:0] REG_MIN_CMD     = 3'd2;
    localparam logic [2:0] REG_ORIENT_TOL  = 3'd3;
    localparam logic [2:0] REG_ORIENT_RATE = 3'd4;
    localparam logic [2:0] REG_DIST_TOL    = 3'd5;
    localparam logic [2:0] REG_DIST_RATE   = 3'd6;

    localparam logic [23:0] ACCEL_DIST_RST  = 24'd0;
    localparam logic [15:0] FULL_CMD_RST    = 16'd65535;
    localparam logic [15:0] MIN_CMD_RST     = 16'd0;
    localparam logic [15:0] ORIENT_TOL_RST  = 16'd0;
    localparam logic [15:0] ORIENT_RATE_RST = 16'd20;
    localparam logic [23:0] DIST_TOL_RST    = 24'd0;
    localparam logic [15:0] DIST_RATE_RST   = 16'd1000;

    // shared unit handshake
    typedef struct packed {
        logic start;
    } mdu_req_t;

    typedef struct packed {
        logic done;
    } mdu_rsp_t;

endpackage

### rtl/move_speed_ramp_and_arrival.sv
// Motor command limiter: trapezoidal speed ramp and arrival detection.
// Input channel s_*: one item per start-translation, start-rotation or
// control tick (kind in s_tuser). Output channel m_*: exactly one result
// item per input item, carrying the limit, action, boosts and arrival flag.
// Configuration channel cfg_*: register index and data, always ready. The
// user must write the seven registers only while the block is idle; the
// block itself does not enforce this. Other indexes are ignored.
// An accepted item passes through S_PREP and S_EVAL to S_OUT, where
// m_tvalid is high; a tick that ramps goes through S_RAMP before S_OUT and
// runs 16 multiply steps and 16 divide steps on one shared adder there.
// One item is in flight at a time: s_tready is high only when idle.
// The result is held in place while m_tready is low; no new item is taken
// until it is delivered.
// Reset: idle, start position 0, limit 65535, both boosts 1, registers at
// their defaults (accel 0, full 65535, min 0, tolerances 0, rate limits 20
// and 1000).
`include "move_speed_ramp_and_arrival_defines.svh"

module move_speed_ramp_and_arrival
    import msra_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // dist_position[31:0], dist_error[63:32], dist_error_rate[95:64],
    // orient_error[127:96], orient_error_rate[159:128]
    input  logic [159:0] s_tdata,
    input  logic [1:0]   s_tuser,   // kind[1:0]
    input  logic         s_tvalid,
    output logic         s_tready,
    // command_limit[15:0], action[17:16], dist_boost[19:18],
    // orient_boost[21:20], arrived[22], zero[23]
    output logic [23:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_EVAL = 5'b00100,
        S_RAMP = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t st_reg, st_next;

    // configuration
    logic [23:0] accel_reg;
    logic [15:0] full_reg, min_reg, otol_reg, orate_lim_reg, drate_lim_reg;
    logic [23:0] dtol_reg;

    // move state
    act_t               act_reg;
    logic signed [31:0] start_reg;
    logic [15:0]        limit_reg;
    logic [1:0]         boost_reg;
    logic               arrived_reg;

    // captured item
    logic [1:0]         kind_reg;
    logic signed [31:0] pos_reg, derr_reg, drate_reg, oerr_reg, orate_reg;

    // magnitudes
    logic [32:0] diff_reg;
    logic [31:0] derr_mag_reg, drate_mag_reg, oerr_mag_reg, orate_mag_reg;
    logic        down_reg;

    logic        in_acc;
    logic [32:0] diff_next;
    logic [32:0] t_mag;
    logic        tick_move, arrive, ramp_acc, ramp_dec, go_ramp;
    logic        down_next;
    logic [X_W-1:0]    x_sel;
    logic [SPAN_W-1:0] span_sel, quot;
    mdu_req_t    mdu_req;
    mdu_rsp_t    mdu_rsp;

    assign cfg_ready = 1'b1;
    assign s_tready  = (st_reg == S_IDLE);
    assign m_tvalid  = (st_reg == S_OUT);
    assign in_acc    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg     <= ACCEL_DIST_RST;
            full_reg      <= FULL_CMD_RST;
            min_reg       <= MIN_CMD_RST;
            otol_reg      <= ORIENT_TOL_RST;
            orate_lim_reg <= ORIENT_RATE_RST;
            dtol_reg      <= DIST_TOL_RST;
            drate_lim_reg <= DIST_RATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACCEL_DIST:  accel_reg     <= cfg_data;
                REG_FULL_CMD:    full_reg      <= cfg_data[15:0];
                REG_MIN_CMD:     min_reg       <= cfg_data[15:0];
                REG_ORIENT_TOL:  otol_reg      <= cfg_data[15:0];
                REG_ORIENT_RATE: orate_lim_reg <= cfg_data[15:0];
                REG_DIST_TOL:    dtol_reg      <= cfg_data;
                REG_DIST_RATE:   drate_lim_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    assign diff_next = {pos_reg[31], pos_reg} - {start_reg[31], start_reg};
    assign t_mag     = diff_reg[32] ? (~diff_reg + 33'd1) : diff_reg;

    assign tick_move = (kind_reg == KIND_TICK) && (act_reg != ACT_IDLE);
    assign arrive    = tick_move
                    && (oerr_mag_reg  < 32'(otol_reg))
                    && (orate_mag_reg < 32'(orate_lim_reg))
                    && (derr_mag_reg  < 32'(dtol_reg))
                    && (drate_mag_reg < 32'(drate_lim_reg));
    assign ramp_acc  = (t_mag < 33'(accel_reg)) && (derr_mag_reg > 32'(accel_reg));
    assign ramp_dec  = derr_mag_reg < 32'(accel_reg);
    // arrival overrides the limit, so the ramp is skipped then
    assign go_ramp   = tick_move && (act_reg == ACT_TRANS) && !arrive
                    && (ramp_acc || ramp_dec);
    assign x_sel     = ramp_acc ? t_mag[X_W-1:0] : derr_mag_reg[X_W-1:0];
    assign down_next = min_reg > full_reg;
    assign span_sel  = down_next ? (min_reg - full_reg) : (full_reg - min_reg);

    assign mdu_req.start = (st_reg == S_EVAL) && go_ramp;

    msra_mdu u_mdu (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mdu_req),
        .x       (x_sel),
        .span    (span_sel),
        .divisor (accel_reg),
        .rsp     (mdu_rsp),
        .quot    (quot)
    );

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (in_acc) st_next = S_PREP;
            S_PREP: st_next = S_EVAL;
            S_EVAL: st_next = go_ramp ? S_RAMP : S_OUT;
            S_RAMP: if (mdu_rsp.done) st_next = S_OUT;
            S_OUT:  if (m_tready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            act_reg     <= ACT_IDLE;
            start_reg   <= '0;
            limit_reg   <= FULL_CMD_RST;
            boost_reg   <= BOOST_NONE;
            arrived_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (in_acc)
                arrived_reg <= 1'b0;
            if (st_reg == S_EVAL)
            begin
                case (kind_reg)
                    KIND_TRANS:
                    begin
                        start_reg <= pos_reg;
                        limit_reg <= full_reg;
                        boost_reg <= BOOST_ORIENT2;
                        act_reg   <= ACT_TRANS;
                    end
                    KIND_ROT:
                    begin
                        limit_reg <= {1'b0, full_reg[15:1]};
                        boost_reg <= BOOST_DIST2;
                        act_reg   <= ACT_ROT;
                    end
                    default:
                    begin
                        if (arrive)
                        begin
                            limit_reg   <= full_reg;
                            boost_reg   <= BOOST_NONE;
                            act_reg     <= ACT_IDLE;
                            arrived_reg <= 1'b1;
                        end
                    end
                endcase
            end
            if (st_reg == S_RAMP && mdu_rsp.done)
                limit_reg <= down_reg ? (min_reg - quot) : (min_reg + quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg  <= s_tuser;
            pos_reg   <= s_tdata[31:0];
            derr_reg  <= s_tdata[63:32];
            drate_reg <= s_tdata[95:64];
            oerr_reg  <= s_tdata[127:96];
            orate_reg <= s_tdata[159:128];
        end
        if (st_reg == S_PREP)
        begin
            diff_reg      <= diff_next;
            derr_mag_reg  <= mag32(derr_reg);
            drate_mag_reg <= mag32(drate_reg);
            oerr_mag_reg  <= mag32(oerr_reg);
            orate_mag_reg <= mag32(orate_reg);
        end
        if (st_reg == S_EVAL)
            down_reg <= down_next;
    end

    assign m_tdata = {1'b0,
                      arrived_reg,
                      boost_reg[BOOST_ORIENT_BIT] ? BOOST_X2 : BOOST_X1,
                      boost_reg[BOOST_DIST_BIT] ? BOOST_X2 : BOOST_X1,
                      act_reg,
                      limit_reg};

    `MSRA_ASSERT_IMP(a_one_in_flight, m_tvalid, !s_tready)
    `MSRA_ASSERT_NXT(a_busy_after_accept, in_acc, !s_tready)
    `MSRA_ASSERT_IMP(a_arrived_idle, m_tvalid && arrived_reg, act_reg == ACT_IDLE)
    `MSRA_ASSERT_IMP(a_single_boost, 1'b1, boost_reg != (BOOST_DIST2 | BOOST_ORIENT2))

endmodule

### rtl/msra_mdu.sv
// Shift-add multiply then restoring divide on one adder:
// quot = (x * span) / divisor, with x < divisor so quot fits SPAN_W bits.
module msra_mdu
    import msra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mdu_req_t          req,
    input  logic [X_W-1:0]    x,
    input  logic [SPAN_W-1:0] span,
    input  logic [X_W-1:0]    divisor,
    output mdu_rsp_t          rsp,
    output logic [SPAN_W-1:0] quot
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } ustate_t;

    ustate_t             st_reg, st_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [X_W-1:0]      x_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic                done_reg, done_next;

    logic [ACC_W:0]      opa, opb, sum;
    logic                sub;
    logic [X_W:0]        rem2;

    assign rem2 = {acc_reg[ACC_W-1:SPAN_W], acc_reg[SPAN_W-1]};

    always_comb
    begin
        opa = '0;
        opb = '0;
        sub = 1'b0;
        case (st_reg)
            U_MUL:
            begin
                opa = {1'b0, acc_reg[ACC_W-2:0], 1'b0};
                opb = span_reg[cnt_reg] ? {{(ACC_W + 1 - X_W){1'b0}}, x_reg} : '0;
            end
            U_DIV:
            begin
                opa = {{(ACC_W - X_W){1'b0}}, rem2};
                opb = {{(ACC_W + 1 - X_W){1'b0}}, divisor};
                sub = 1'b1;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // the one shared adder/subtractor
    assign sum = opa + (sub ? ~opb : opb) + {{ACC_W{1'b0}}, sub};

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        case (st_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    st_next  = U_MUL;
                    cnt_next = CNT_W'(SPAN_W - 1);
                    acc_next = '0;
                end
            end
            U_MUL:
            begin
                acc_next = sum[ACC_W-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    st_next  = U_DIV;
                    cnt_next = CNT_W'(SPAN_W - 1);
                end
            end
            U_DIV:
            begin
                // negative difference: keep the shifted remainder
                if (sum[ACC_W])
                    acc_next = {rem2[X_W-1:0], acc_reg[SPAN_W-2:0], 1'b0};
                else
                    acc_next = {sum[X_W-1:0], acc_reg[SPAN_W-2:0], 1'b1};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    st_next   = U_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= U_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (st_reg == U_IDLE && req.start)
        begin
            x_reg    <= x;
            span_reg <= span;
        end
    end

    assign rsp.done = done_reg;
    assign quot     = acc_reg[SPAN_W-1:0];

endmodule
